/* rtl/core/psrmt_pkg.sv */
package psrmt_pkg;

  // Trust figure format: unsigned Q0.16
  localparam int TRUST_BITS = 16;
  localparam logic [TRUST_BITS-1:0] HALF_Q16 = 16'h8000;
  localparam int DIV_CNT_W = $clog2(TRUST_BITS);

  // Reported error counter width
  localparam int ERR_OUT_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IPV4_PROTO   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTING_PORT = 4'd1;
  localparam logic [CFG_DATA_W-1:0] IPV4_PROTO_RST   = 16'd2048;
  localparam logic [CFG_DATA_W-1:0] ROUTING_PORT_RST = 16'd654;

  // Route message types
  localparam logic [7:0] MSG_REQUEST = 8'd1;
  localparam logic [7:0] MSG_REPLY   = 8'd2;
  localparam logic [7:0] MSG_ERROR   = 8'd3;

  typedef struct packed {
    logic [15:0] link_protocol;
    logic [31:0] source_address;
    logic [15:0] udp_dest_port;
    logic [7:0]  message_type;
    logic        to_broadcast;
  } req_item_t;

  typedef struct packed {
    logic                    accepted;
    logic [TRUST_BITS-1:0]   trust_value;
    logic [ERR_OUT_BITS-1:0] error_count;
    logic                    table_full;
  } result_item_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } core_state_t;

endpackage

/* rtl/core/per_source_route_msg_trust_core.sv */
// Channel | Ports                          | Handshake
// --------+--------------------------------+------------------------------------------
// request | start, busy, in_req            | taken at an edge with start=1, busy=0
// result  | out_valid, out_res             | one-cycle strobe, cannot be held off
// config  | cfg_we, cfg_index, cfg_wdata   | written at an edge with cfg_we=1
//
// A non-matching request gets its all-zero result in the next cycle; the core stays free.
// A matching request scans the table one entry per cycle through a registered read port
// up to the first hit or the last used entry, then takes a write-back step, 16 divider
// steps (none when the source has no requests) and one result step that strobes out_valid.
// Sync reset empties the table through the fill count; results never stall, busy holds off.
module per_source_route_msg_trust_core
  import psrmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int COUNTER_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  req_item_t             in_req,
  output logic                  out_valid,
  output result_item_t          out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CB     = COUNTER_BITS;
  localparam int DEN_W  = CB + 1;
  localparam int REM_W  = CB + 2;
  localparam int EXT_W  = (CB > ERR_OUT_BITS) ? CB : ERR_OUT_BITS;
  localparam logic [CB-1:0]     CNT_MAX  = {CB{1'b1}};
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic [31:0]   addr;
    logic [CB-1:0] req;
    logic [CB-1:0] rep;
    logic [CB-1:0] err;
  } entry_t;

  // Source table memory
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Control state
  core_state_t       state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pend_r, pend_nxt;
  logic [CFG_DATA_W-1:0] proto_r, proto_nxt;
  logic [CFG_DATA_W-1:0] port_r, port_nxt;

  // Working payload
  req_item_t         item_r, item_nxt;
  logic [FILL_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [CB-1:0]     req_r, req_nxt;
  logic [CB-1:0]     rep_r, rep_nxt;
  logic [CB-1:0]     err_r, err_nxt;
  logic              full_r, full_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [TRUST_BITS-1:0] quot_r, quot_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  result_item_t      out_res_r, out_res_nxt;

  // Datapath helpers
  logic              issue;
  logic              hit_now;
  logic              full_now;
  logic [CB-1:0]     req_new, rep_new, err_new;
  logic [REM_W-1:0]  rem_dbl;
  logic              rem_ge;
  logic [EXT_W-1:0]  err_ext;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign issue   = (state_r == ST_SCAN) && (scan_idx_r < fill_r);
  assign rd_addr = scan_idx_r[IDX_W-1:0];
  assign hit_now = pend_r && (rd_data_r.addr == item_r.source_address);

  assign full_now = !hit_r && (fill_r == FILL_MAX);

  // Apply the message to the counters, saturating
  always_comb begin
    req_new = req_r;
    rep_new = rep_r;
    err_new = err_r;
    case (item_r.message_type)
      MSG_REQUEST: begin
        if (req_r != CNT_MAX) req_new = req_r + 1'b1;
      end
      MSG_REPLY: begin
        if (!item_r.to_broadcast && rep_r != CNT_MAX) rep_new = rep_r + 1'b1;
      end
      MSG_ERROR: begin
        if (err_r != CNT_MAX) err_new = err_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // One restoring divider step
  assign rem_dbl = {rem_r[REM_W-2:0], 1'b0};
  assign rem_ge  = (rem_dbl >= {1'b0, den_r});

  assign err_ext = EXT_W'(err_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hit_r ? hit_idx_r : fill_r[IDX_W-1:0];
    mem_wdata = '{addr: item_r.source_address, req: req_new, rep: rep_new, err: err_new};

    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    pend_nxt      = pend_r;
    proto_nxt     = proto_r;
    port_nxt      = port_r;
    item_nxt      = item_r;
    scan_idx_nxt  = scan_idx_r;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    req_nxt       = req_r;
    rep_nxt       = rep_r;
    err_nxt       = err_r;
    full_nxt      = full_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    cnt_nxt       = cnt_r;
    out_res_nxt   = out_res_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_IPV4_PROTO:   proto_nxt = cfg_wdata;
        REG_ROUTING_PORT: port_nxt  = cfg_wdata;
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_req;
          if (in_req.link_protocol == proto_r && in_req.udp_dest_port == port_r) begin
            scan_idx_nxt = '0;
            pend_nxt     = 1'b0;
            state_nxt    = ST_SCAN;
          end else begin
            // Drop: report an all-zero result
            out_valid_nxt = 1'b1;
            out_res_nxt   = '0;
          end
        end
      end
      ST_SCAN: begin
        pend_nxt     = issue;
        pend_idx_nxt = scan_idx_r[IDX_W-1:0];
        if (issue) scan_idx_nxt = scan_idx_r + 1'b1;
        if (hit_now) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pend_idx_r;
          req_nxt     = rd_data_r.req;
          rep_nxt     = rd_data_r.rep;
          err_nxt     = rd_data_r.err;
          pend_nxt    = 1'b0;
          state_nxt   = ST_UPDATE;
        end else if (!pend_r && !issue) begin
          hit_nxt   = 1'b0;
          req_nxt   = '0;
          rep_nxt   = '0;
          err_nxt   = '0;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        full_nxt = full_now;
        req_nxt  = req_new;
        rep_nxt  = rep_new;
        err_nxt  = err_new;
        if (!full_now) begin
          mem_we = 1'b1;
          if (!hit_r) fill_nxt = fill_r + 1'b1;
        end
        den_nxt  = DEN_W'(req_new) + DEN_W'(rep_new);
        rem_nxt  = REM_W'(rep_new);
        cnt_nxt  = '0;
        if (req_new == '0) begin
          quot_nxt  = HALF_Q16;
          state_nxt = ST_DONE;
        end else begin
          quot_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? (rem_dbl - REM_W'(den_r)) : rem_dbl;
        quot_nxt = {quot_r[TRUST_BITS-2:0], rem_ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(TRUST_BITS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid_nxt           = 1'b1;
        out_res_nxt.accepted    = 1'b1;
        out_res_nxt.trust_value = quot_r;
        out_res_nxt.error_count = (err_ext > EXT_W'({ERR_OUT_BITS{1'b1}})) ?
                                  {ERR_OUT_BITS{1'b1}} : err_ext[ERR_OUT_BITS-1:0];
        out_res_nxt.table_full  = full_r;
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Table memory: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      proto_r     <= IPV4_PROTO_RST;
      port_r      <= ROUTING_PORT_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      proto_r     <= proto_nxt;
      port_r      <= port_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    req_r      <= req_nxt;
    rep_r      <= rep_nxt;
    err_r      <= err_nxt;
    full_r     <= full_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quot_r     <= quot_nxt;
    cnt_r      <= cnt_nxt;
    out_res_r  <= out_res_nxt;
  end

`ifndef SYNTHESIS
  // The fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count beyond table size");

  // The fill count only grows, one entry at a time
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> (fill_r == $past(fill_r) + 1'b1))
    else $error("fill count moved by more than one");

  // A full-table result is always an accepted one
  a_full_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.table_full) |-> out_res.accepted)
    else $error("table_full on an unmatched request");

  // A matching request occupies the core on the next cycle
  a_match_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.link_protocol == proto_r && in_req.udp_dest_port == port_r)
      |=> (busy && !out_valid))
    else $error("matching request did not start a lookup");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import psrmt_pkg::*;

  // Message types the package leaves unnamed
  localparam logic [7:0] MSG_REPLY_ACK  = 8'd4;
  localparam logic [7:0] MSG_TYPE_ZERO  = 8'd0;
  localparam logic [7:0] MSG_TYPE_TOP   = 8'd255;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  localparam int TBL_DEPTH  = 64;
  localparam int CNT_BITS   = 16;
  localparam logic [CNT_BITS-1:0] CNT_CAP = '1;

  localparam int POOL_SIZE    = 40;
  localparam int SAT_ITEMS    = 60;
  localparam logic [31:0] SAT_SOURCE = 32'h0A00_0001;
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  req_item_t    in_req = '0;
  logic         out_valid;
  result_item_t out_res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  per_source_route_msg_trust_core #(
    .TABLE_ENTRIES(TBL_DEPTH),
    .COUNTER_BITS (CNT_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the source table and the two match registers
  // ---------------------------------------------------------------------------
  logic [15:0]         shadow_proto;
  logic [15:0]         shadow_port;
  bit                  src_valid [TBL_DEPTH];
  logic [31:0]         src_addr  [TBL_DEPTH];
  logic [CNT_BITS-1:0] src_req   [TBL_DEPTH];
  logic [CNT_BITS-1:0] src_rep   [TBL_DEPTH];
  logic [CNT_BITS-1:0] src_err   [TBL_DEPTH];

  result_item_t expected_results[$];
  logic [31:0]  source_pool[POOL_SIZE];

  longint cycle_count = 0;
  int     mismatch_count = 0;
  int     result_count = 0;
  int     matched_sent = 0;
  int     ignored_sent = 0;
  int     full_predicted = 0;
  int     cfg_writes = 0;
  bit     pace_on = 1'b1;
  int     burst_left = 0;

  function automatic logic [CNT_BITS-1:0] bump_sat(logic [CNT_BITS-1:0] v);
    return (v == CNT_CAP) ? v : v + 1'b1;
  endfunction

  // Work out the result of one request and advance the shadow table
  function automatic result_item_t predict_trust_result(req_item_t it);
    result_item_t        r;
    int                  hit;
    int                  free_slot;
    int                  slot;
    bit                  full;
    logic [CNT_BITS-1:0] nreq;
    logic [CNT_BITS-1:0] nrep;
    logic [CNT_BITS-1:0] nerr;
    longint unsigned     num;
    longint unsigned     den;
    longint unsigned     quo;
    r = '0;
    if (it.link_protocol != shadow_proto || it.udp_dest_port != shadow_port)
      return r;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (src_valid[i]) begin
        if (hit < 0 && src_addr[i] == it.source_address) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    nreq = '0;
    nrep = '0;
    nerr = '0;
    full = 1'b0;
    if (hit >= 0) begin
      nreq = src_req[hit];
      nrep = src_rep[hit];
      nerr = src_err[hit];
    end else if (free_slot < 0) begin
      full = 1'b1;
    end
    // broadcast replies and unknown types leave every counter alone
    if (it.message_type == MSG_REQUEST) nreq = bump_sat(nreq);
    else if (it.message_type == MSG_REPLY) begin
      if (!it.to_broadcast) nrep = bump_sat(nrep);
    end else if (it.message_type == MSG_ERROR) nerr = bump_sat(nerr);
    if (!full) begin
      slot = (hit >= 0) ? hit : free_slot;
      src_valid[slot] = 1'b1;
      src_addr[slot]  = it.source_address;
      src_req[slot]   = nreq;
      src_rep[slot]   = nrep;
      src_err[slot]   = nerr;
    end
    r.accepted = 1'b1;
    if (nreq == '0) begin
      r.trust_value = HALF_Q16;
    end else begin
      num = longint'(nrep) << 16;
      den = longint'(nreq) + longint'(nrep);
      quo = num / den;
      r.trust_value = quo[15:0];
    end
    r.error_count = nerr;
    r.table_full  = full;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      result_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no request waiting: acc=%0b trust=%0d err=%0d full=%0b",
                   $realtime, out_res.accepted, out_res.trust_value, out_res.error_count,
                   out_res.table_full);
      end else begin
        want = expected_results.pop_front();
        if (out_res.accepted !== want.accepted || out_res.trust_value !== want.trust_value ||
            out_res.error_count !== want.error_count ||
            out_res.table_full !== want.table_full) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch exp acc=%0b trust=%0d err=%0d full=%0b",
                     $realtime, want.accepted, want.trust_value, want.error_count,
                     want.table_full);
            $display("%0t:          got acc=%0b trust=%0d err=%0d full=%0b",
                     $realtime, out_res.accepted, out_res.trust_value,
                     out_res.error_count, out_res.table_full);
          end
        end
      end
    end
  end

  // Watchdog: end the run if the core stops answering
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog expired after %0d cycles", cycle_count);
    $display("** per_source_route_msg_trust_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the core takes it. Start is left
  // high on return so back-to-back requests need no extra assignment.
  task automatic send_req(input req_item_t item);
    int unsigned gap;
    result_item_t pred;
    gap = 0;
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : $urandom_range(0, 4);
      end
      burst_left--;
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= item;
    start  <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pred = predict_trust_result(item);
    expected_results.push_back(pred);
    if (pred.accepted) matched_sent++;
    else ignored_sent++;
    if (pred.table_full) full_predicted++;
  endtask

  // Drop start and wait until every prediction has been answered
  task automatic wait_for_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; only called with the core idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IPV4_PROTO) shadow_proto = val;
    else if (idx == REG_ROUTING_PORT) shadow_port = val;
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic req_item_t route_msg(logic [15:0] proto, logic [31:0] addr,
                                          logic [15:0] port, logic [7:0] mtype, logic bcast);
    req_item_t it;
    it.link_protocol  = proto;
    it.source_address = addr;
    it.udp_dest_port  = port;
    it.message_type   = mtype;
    it.to_broadcast   = bcast;
    return it;
  endfunction

  // Matching request with a random message type, weighted toward the counted ones
  function automatic req_item_t make_route_msg(logic [31:0] addr);
    logic [7:0] mtype;
    case ($urandom_range(0, 9))
      0, 1, 2: mtype = MSG_REQUEST;
      3, 4, 5: mtype = MSG_REPLY;
      6, 7:    mtype = MSG_ERROR;
      8:       mtype = MSG_REPLY_ACK;
      default: mtype = 8'($urandom_range(0, 255));
    endcase
    return route_msg(shadow_proto, addr, shadow_port, mtype, 1'($urandom_range(0, 1)));
  endfunction

  // Request that should miss: random header or a single flipped bit
  function automatic req_item_t make_noise_msg();
    req_item_t it;
    it = make_route_msg($urandom);
    case ($urandom_range(0, 2))
      0: begin
        it.link_protocol = 16'($urandom);
        it.udp_dest_port = 16'($urandom);
      end
      1: it.link_protocol = it.link_protocol ^ (16'd1 << $urandom_range(0, 15));
      default: it.udp_dest_port = it.udp_dest_port ^ (16'd1 << $urandom_range(0, 15));
    endcase
    return it;
  endfunction

  // Mix of matching and noise requests until enough have matched
  task automatic run_traffic(input int n_matched, input int noise_pct, input bit fresh_sources);
    int done_cnt;
    req_item_t it;
    done_cnt = 0;
    while (done_cnt < n_matched) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_req(make_noise_msg());
      end else begin
        if (fresh_sources && $urandom_range(0, 1)) it = make_route_msg($urandom);
        else it = make_route_msg(source_pool[$urandom_range(0, POOL_SIZE - 1)]);
        send_req(it);
        done_cnt++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pile errors and replies on one source back to back. The source has no
  // requests, so the divider is skipped and each request stays short.
  task automatic test_single_source();
    pace_on = 1'b0;
    repeat (SAT_ITEMS)
      send_req(route_msg(shadow_proto, SAT_SOURCE, shadow_port, MSG_ERROR, 1'b0));
    repeat (SAT_ITEMS)
      send_req(route_msg(shadow_proto, SAT_SOURCE, shadow_port, MSG_REPLY, 1'b0));
    send_req(route_msg(shadow_proto, SAT_SOURCE, shadow_port, MSG_REPLY, 1'b1));
    // add requests against the built-up reply count
    repeat (4)
      send_req(route_msg(shadow_proto, SAT_SOURCE, shadow_port, MSG_REQUEST,
                         1'($urandom_range(0, 1))));
    pace_on = 1'b1;
    wait_for_idle();
  endtask

  // Field extremes, every message type and the no-match cases
  task automatic test_directed_fields();
    // no match: protocol off, port off, protocol off again, then both off at zero
    send_req(route_msg(16'h0000, 32'hFFFF_FFFF, shadow_port, MSG_TYPE_TOP, 1'b1));
    send_req(route_msg(shadow_proto, 32'hFFFF_FFFF, 16'hFFFF, MSG_REQUEST, 1'b1));
    send_req(route_msg(16'hFFFF, 32'h0000_0000, shadow_port, MSG_REPLY, 1'b0));
    send_req(route_msg(16'h0000, 32'h0000_0000, 16'h0000, MSG_TYPE_ZERO, 1'b0));
    // one source through request, reply, error and reply-ack messages
    send_req(route_msg(shadow_proto, 32'h0000_0000, shadow_port, MSG_REQUEST, 1'b0));
    send_req(route_msg(shadow_proto, 32'h0000_0000, shadow_port, MSG_REPLY, 1'b0));
    send_req(route_msg(shadow_proto, 32'h0000_0000, shadow_port, MSG_REPLY, 1'b1));
    send_req(route_msg(shadow_proto, 32'h0000_0000, shadow_port, MSG_ERROR, 1'b0));
    send_req(route_msg(shadow_proto, 32'h0000_0000, shadow_port, MSG_REPLY_ACK, 1'b0));
    send_req(route_msg(shadow_proto, 32'h0000_0000, shadow_port, MSG_REQUEST, 1'b1));
    // unknown types still allocate the source
    send_req(route_msg(shadow_proto, 32'hFFFF_FFFF, shadow_port, MSG_TYPE_ZERO, 1'b0));
    send_req(route_msg(shadow_proto, 32'hFFFF_FFFF, shadow_port, MSG_TYPE_TOP, 1'b1));
    send_req(route_msg(shadow_proto, 32'hFFFF_FFFF, shadow_port, MSG_REPLY, 1'b0));
    send_req(route_msg(shadow_proto, 32'hFFFF_FFFF, shadow_port, MSG_REQUEST, 1'b1));
    send_req(route_msg(shadow_proto, 32'hFFFF_FFFF, shadow_port, MSG_REPLY, 1'b0));
    // broadcast reply as the very first message of a new source
    send_req(route_msg(shadow_proto, 32'hA5A5_5A5A, shadow_port, MSG_REPLY, 1'b1));
    send_req(route_msg(shadow_proto, 32'hA5A5_5A5A, shadow_port, MSG_REQUEST, 1'b0));
    wait_for_idle();
  endtask

  // Both registers at both extremes, plus writes to indexes with no register
  task automatic test_config_registers();
    write_reg(REG_IPV4_PROTO, 16'h0000);
    write_reg(REG_ROUTING_PORT, 16'h0000);
    send_req(route_msg(16'h0000, 32'h0000_0000, 16'h0000, MSG_REQUEST, 1'b0));
    send_req(route_msg(16'h0000, 32'h0000_0000, 16'h0001, MSG_REQUEST, 1'b0));
    send_req(route_msg(IPV4_PROTO_RST, 32'h0000_0000, ROUTING_PORT_RST, MSG_REPLY, 1'b0));
    wait_for_idle();
    write_reg(REG_IPV4_PROTO, 16'hFFFF);
    write_reg(REG_ROUTING_PORT, 16'hFFFF);
    send_req(route_msg(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, MSG_ERROR, 1'b0));
    send_req(route_msg(16'hFFFE, 32'hFFFF_FFFF, 16'hFFFF, MSG_ERROR, 1'b0));
    wait_for_idle();
    // these must leave the match registers as they are
    write_reg(REG_UNUSED_LO, 16'h0000);
    write_reg(REG_UNUSED_HI, 16'h0000);
    send_req(route_msg(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, MSG_REPLY, 1'b0));
    send_req(route_msg(16'h0000, 32'hFFFF_FFFF, 16'h0000, MSG_REPLY, 1'b0));
    wait_for_idle();
    write_reg(REG_IPV4_PROTO, IPV4_PROTO_RST);
    write_reg(REG_ROUTING_PORT, ROUTING_PORT_RST);
  endtask

  // Random traffic over a fixed source pool, under several register settings
  task automatic test_random_traffic();
    wait_for_idle();
    run_traffic(300, 20, 1'b0);
    wait_for_idle();
    write_reg(REG_IPV4_PROTO, 16'($urandom));
    write_reg(REG_ROUTING_PORT, 16'($urandom));
    run_traffic(300, 20, 1'b0);
    wait_for_idle();
    write_reg(REG_IPV4_PROTO, 16'hFFFF);
    write_reg(REG_ROUTING_PORT, 16'h0000);
    run_traffic(300, 20, 1'b0);
    wait_for_idle();
    write_reg(REG_IPV4_PROTO, 16'h0000);
    write_reg(REG_ROUTING_PORT, 16'hFFFF);
    run_traffic(300, 20, 1'b0);
    wait_for_idle();
  endtask

  // Fresh sources fill the rest of the table, then keep arriving once it is full
  task automatic test_table_full();
    write_reg(REG_IPV4_PROTO, IPV4_PROTO_RST);
    write_reg(REG_ROUTING_PORT, ROUTING_PORT_RST);
    run_traffic(270, 10, 1'b1);
    wait_for_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    shadow_proto = IPV4_PROTO_RST;
    shadow_port  = ROUTING_PORT_RST;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      src_valid[i] = 1'b0;
      src_addr[i]  = '0;
      src_req[i]   = '0;
      src_rep[i]   = '0;
      src_err[i]   = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) source_pool[i] = $urandom;
    source_pool[0] = 32'h0000_0000;
    source_pool[1] = 32'hFFFF_FFFF;

    // hold reset low, then release it for good
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_source();
    test_directed_fields();
    test_config_registers();
    test_random_traffic();
    test_table_full();

    // let any stray strobe show up before judging
    start <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d predicted results never arrived", expected_results.size());
      mismatch_count += expected_results.size();
    end

    $display("sent %0d matching and %0d non-matching requests, %0d table-full cases",
             matched_sent, ignored_sent, full_predicted);
    $display("checked %0d results across %0d register writes in %0d cycles, %0d mismatches",
             result_count, cfg_writes, cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** per_source_route_msg_trust_core: PASSED **");
    end else begin
      $display("** per_source_route_msg_trust_core: FAILED **");
    end
    $finish;
  end

endmodule
